// ===== rtl/euler_to_quaternion_core_macros.svh =====
// Assertion macros for the Euler to quaternion block
`ifndef EULER_TO_QUATERNION_CORE_MACROS_SVH
`define EULER_TO_QUATERNION_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define E2Q_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("e2q check failed");
// Next-cycle implication checked outside reset
`define E2Q_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("e2q check failed");
`endif

// ===== rtl/e2q_pkg.sv =====
// Package: types, constants and CORDIC table for the Euler to quaternion block
package e2q_pkg;
  localparam int unsigned AngleWidth    = 17;
  localparam int unsigned AngleFracBits = 7;
  localparam int unsigned QuatWidth     = 16;
  localparam int unsigned TrigWidth     = 33;
  localparam int unsigned PhaseWidth    = 33;
  localparam logic signed [TrigWidth-1:0] CordicGain = 33'sd652032874;

  typedef logic signed [AngleWidth-1:0] angle_t;
  typedef logic signed [QuatWidth-1:0]  quat_t;
  typedef logic signed [TrigWidth-1:0]  trig_t;
  typedef logic signed [PhaseWidth-1:0] phase_t;

  // One CORDIC lane state for one angle
  typedef struct packed {
    trig_t  x;
    trig_t  y;
    phase_t z;
    logic   neg;
  } lane_t;

  typedef struct packed {
    lane_t lx;
    lane_t ly;
    lane_t lz;
  } cell_t;

  typedef struct packed {
    quat_t w;
    quat_t x;
    quat_t y;
    quat_t z;
  } quat_item_t;

  // Arctangent in phase units, 2^32 per turn
  function automatic phase_t atan_phase(input logic [4:0] k);
    phase_t r;
    r = '0;
    case (k)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      5'd30: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One CORDIC micro-rotation
  function automatic lane_t rotate(input lane_t a, input logic [4:0] k);
    lane_t r;
    trig_t dx;
    trig_t dy;
    dx = a.y >>> k;
    dy = a.x >>> k;
    r  = a;
    if (!a.z[PhaseWidth-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_phase(k);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_phase(k);
    end
    return r;
  endfunction
endpackage

// ===== rtl/e2q_if.sv =====
// Valid/ready channel interface carrying one payload item
interface e2q_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/euler_to_quaternion_core.sv =====
// Euler ZYX angles to quaternion: one item per cycle through a chain of CORDIC cells.
// Stages in order: one phase-prep stage, one cell per
// iteration, two product stages and the output register. The whole chain
// advances together when the output register is free or being read, so an item
// can enter on every cycle; throughput is set by that single shared advance.
module euler_to_quaternion_core #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  e2q_if.sink   in_i,
  e2q_if.source out_o
);
  localparam int unsigned Depth = CORDIC_ITERATIONS + 4;

  logic [Depth-1:0] vld_q;
  logic             adv;
  e2q_pkg::cell_t   chain [CORDIC_ITERATIONS+1];
  e2q_pkg::angle_t  ax, ay, az;

  assign adv         = !vld_q[Depth-1] || out_o.ready;
  assign in_i.ready  = adv;
  assign out_o.valid = vld_q[Depth-1];
  assign ax = in_i.data[3*e2q_pkg::AngleWidth-1 -: e2q_pkg::AngleWidth];
  assign ay = in_i.data[2*e2q_pkg::AngleWidth-1 -: e2q_pkg::AngleWidth];
  assign az = in_i.data[e2q_pkg::AngleWidth-1:0];

  // Valid bits follow the data through the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_i.valid};
    end
  end

  e2q_prep u_prep_x (.clk_i, .en_i(adv), .angle_i(ax), .lane_o(chain[0].lx));
  e2q_prep u_prep_y (.clk_i, .en_i(adv), .angle_i(ay), .lane_o(chain[0].ly));
  e2q_prep u_prep_z (.clk_i, .en_i(adv), .angle_i(az), .lane_o(chain[0].lz));

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
    e2q_cell #(.Step(i)) u_cell (
      .clk_i, .en_i(adv), .cell_i(chain[i]), .cell_o(chain[i+1])
    );
  end

  e2q_combine u_comb (
    .clk_i, .en_i(adv), .cell_i(chain[CORDIC_ITERATIONS]), .quat_o(out_o.data)
  );
endmodule

// ===== rtl/e2q_prep.sv =====
// Angle to half-angle phase with quadrant fold, one pipeline stage
module e2q_prep (
  input  logic               clk_i,
  input  logic               en_i,
  input  e2q_pkg::angle_t    angle_i,
  output e2q_pkg::lane_t     lane_o
);
  // 2^32 / (720 * 2^frac) = 2^Sh / 45
  localparam int unsigned Sh = 28 - e2q_pkg::AngleFracBits;
  // ceil(2^24 / 45), exact quotient for any 17-bit magnitude
  localparam logic [18:0] Recip45 = 19'd372828;

  // Rounded fraction part for each remainder: floor((r * 2^Sh + 22) / 45)
  function automatic logic [45*32-1:0] frac_table();
    logic [45*32-1:0] t;
    t = '0;
    for (int r = 0; r < 45; r++) begin
      t[r*32 +: 32] = 32'(((64'(r) << Sh) + 64'd22) / 64'd45);
    end
    return t;
  endfunction

  localparam logic [45*32-1:0] FracTbl = frac_table();

  logic [16:0]  mag;
  logic [34:0]  mq;
  logic [10:0]  m;
  logic [16:0]  m45;
  logic [5:0]   r;
  logic [31:0]  qr;
  logic [31:0]  ph;
  logic signed [33:0] z;
  e2q_pkg::lane_t lane_d, lane_q;

  // |a| * 2^32 / Den rounded half up: split |a| = 45*m + r, table for r
  always_comb begin
    mag  = angle_i[16] ? 17'(-angle_i) : angle_i;
    mq   = 35'(mag) * 35'(Recip45);
    m    = mq[34:24];
    m45  = 17'(m) * 17'd45;
    r    = 6'(mag - m45);
    qr   = (32'(m) << Sh) + FracTbl[{r, 5'd0} +: 32];
    ph   = angle_i[16] ? 32'(-qr) : qr;
    z    = 34'(signed'({2'b00, ph}));
    if (ph[31]) z = z - 34'sd4294967296;
    lane_d     = '0;
    lane_d.x   = e2q_pkg::CordicGain;
    lane_d.y   = '0;
    lane_d.neg = 1'b0;
    if (z > 34'sd1073741824) begin
      z = z - 34'sd2147483648;
      lane_d.neg = 1'b1;
    end else if (z < -34'sd1073741824) begin
      z = z + 34'sd2147483648;
      lane_d.neg = 1'b1;
    end
    lane_d.z = z[32:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end
  assign lane_o = lane_q;
endmodule

// ===== rtl/e2q_cell.sv =====
// One CORDIC cell: a micro-rotation on all three lanes, registered
module e2q_cell #(
  parameter int unsigned Step = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  e2q_pkg::cell_t cell_i,
  output e2q_pkg::cell_t cell_o
);
  localparam logic [4:0] K = 5'(Step % 32);
  e2q_pkg::cell_t cell_d, cell_q;

  always_comb begin
    cell_d.lx = e2q_pkg::rotate(cell_i.lx, K);
    cell_d.ly = e2q_pkg::rotate(cell_i.ly, K);
    cell_d.lz = e2q_pkg::rotate(cell_i.lz, K);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end
  assign cell_o = cell_q;
endmodule

// ===== rtl/e2q_combine.sv =====
// Triple-product combine: pair products, triple products, sum and saturate
module e2q_combine (
  input  logic               clk_i,
  input  logic               en_i,
  input  e2q_pkg::cell_t     cell_i,
  output e2q_pkg::quat_item_t quat_o
);
  typedef logic signed [31:0] v_t;
  typedef logic signed [63:0] p_t;

  v_t cx, sx, cy, sy, cz, sz;
  v_t cx_q, sx_q;
  v_t czcy_q, szsy_q, szcy_q, czsy_q;
  p_t t_d [8];
  p_t t_q [8];
  e2q_pkg::quat_item_t q_d, q_q;

  function automatic v_t fix(input e2q_pkg::trig_t v, input logic n);
    e2q_pkg::trig_t r;
    r = n ? -v : v;
    return r[31:0];
  endfunction

  function automatic v_t mq30(input v_t a, input v_t b);
    p_t p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

  function automatic e2q_pkg::quat_t sat(input p_t s);
    p_t r;
    r = (s + 64'sd17592186044416) >>> 45;
    if (r > 64'sd32767) return 16'sd32767;
    if (r < -64'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  always_comb begin
    cx = fix(cell_i.lx.x, cell_i.lx.neg);
    sx = fix(cell_i.lx.y, cell_i.lx.neg);
    cy = fix(cell_i.ly.x, cell_i.ly.neg);
    sy = fix(cell_i.ly.y, cell_i.ly.neg);
    cz = fix(cell_i.lz.x, cell_i.lz.neg);
    sz = fix(cell_i.lz.y, cell_i.lz.neg);
  end

  // Stage 1: pair products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      czcy_q <= mq30(cz, cy);
      szsy_q <= mq30(sz, sy);
      szcy_q <= mq30(sz, cy);
      czsy_q <= mq30(cz, sy);
      cx_q   <= cx;
      sx_q   <= sx;
    end
  end

  // Stage 2: triple products
  always_comb begin
    t_d[0] = 64'(czcy_q) * 64'(cx_q);
    t_d[1] = 64'(szsy_q) * 64'(sx_q);
    t_d[2] = 64'(szcy_q) * 64'(cx_q);
    t_d[3] = 64'(czsy_q) * 64'(sx_q);
    t_d[4] = 64'(czsy_q) * 64'(cx_q);
    t_d[5] = 64'(szcy_q) * 64'(sx_q);
    t_d[6] = 64'(czcy_q) * 64'(sx_q);
    t_d[7] = 64'(szsy_q) * 64'(cx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  // Stage 3: sums, rounding and saturation
  always_comb begin
    q_d.w = sat(t_q[0] + t_q[1]);
    q_d.x = sat(t_q[2] - t_q[3]);
    q_d.y = sat(t_q[4] + t_q[5]);
    q_d.z = sat(t_q[6] - t_q[7]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end
  assign quat_o = q_q;
endmodule

// ===== rtl/e2q_checker.sv =====
// Port-level checker for the Euler to quaternion block, bound to the top level
`include "euler_to_quaternion_core_macros.svh"
module e2q_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input e2q_pkg::quat_item_t out_data
);
  `E2Q_ASSERT_IMPL(a_ready_when_free, clk_i, rst_ni, !out_valid, in_ready)
  `E2Q_ASSERT_IMPL(a_ready_when_taken, clk_i, rst_ni, out_ready, in_ready)
  `E2Q_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  `E2Q_ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, out_valid && !out_ready, !in_ready)
endmodule

bind euler_to_quaternion_core e2q_assert u_e2q_assert (
  .clk_i, .rst_ni,
  .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);

// ===== tb/e2q_checker.sv =====
// Checker for the Euler to quaternion block: watches both channels, predicts and compares
module e2q_checker
  import e2q_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  angle_t     ang_x_i,
  input  angle_t     ang_y_i,
  input  angle_t     ang_z_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  quat_item_t quat_i,
  output int         errors_o,
  output int         pending_o
);
  localparam int unsigned Iterations = 16;
  localparam int unsigned FracBits   = 7;
  localparam longint PhaseQuarter = 64'sd1073741824;
  localparam longint PhaseHalf    = 64'sd2147483648;
  localparam longint GainQ30      = 64'sd652032874;

  longint atan_lut [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  quat_item_t quat_q[$];
  int errors;

  // Cosine and sine of half the angle, scaled by 2^30
  task automatic half_angle_trig(input angle_t ang, output longint c, output longint s);
    longint a, z, x, y, dx, dy;
    longint unsigned mag, den, q;
    logic [31:0] ph;
    logic neg;
    a   = longint'(ang);
    den = 64'd720 << FracBits;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    q   = ((mag << 32) + (den >> 1)) / den;
    ph  = (a < 0) ? 32'(64'd0 - q) : q[31:0];
    z   = longint'({32'd0, ph});
    if (z >= PhaseHalf) z = z - 2 * PhaseHalf;
    neg = 1'b0;
    // fold into +-90 degrees; the half turn flips both outputs
    if (z > PhaseQuarter) begin
      z = z - PhaseHalf;
      neg = 1'b1;
    end else if (z < -PhaseQuarter) begin
      z = z + PhaseHalf;
      neg = 1'b1;
    end
    x = GainQ30;
    y = 0;
    for (int i = 0; i < Iterations; i++) begin
      dx = y >>> (i % 32);
      dy = x >>> (i % 32);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_lut[i % 32];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_lut[i % 32];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic longint mul_round30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic quat_t round_sat_q15(input longint sum60);
    longint r;
    r = (sum60 + (64'sd1 <<< 44)) >>> 45;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return quat_t'(r[15:0]);
  endfunction

  task automatic predict_quat(input angle_t ax, input angle_t ay, input angle_t az,
                              output quat_item_t q);
    longint cx, sx, cy, sy, cz, sz, czcy, szsy, szcy, czsy;
    half_angle_trig(ax, cx, sx);
    half_angle_trig(ay, cy, sy);
    half_angle_trig(az, cz, sz);
    czcy = mul_round30(cz, cy);
    szsy = mul_round30(sz, sy);
    szcy = mul_round30(sz, cy);
    czsy = mul_round30(cz, sy);
    q.w = round_sat_q15(czcy * cx + szsy * sx);
    q.x = round_sat_q15(szcy * cx - czsy * sx);
    q.y = round_sat_q15(czsy * cx + szcy * sx);
    q.z = round_sat_q15(czcy * sx - szsy * cx);
  endtask

  // Queue a prediction per accepted item, compare each result with the oldest
  always @(posedge clk_i or negedge rst_ni) begin
    quat_item_t q, want;
    if (!rst_ni) begin
      errors = 0;
      quat_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_quat(ang_x_i, ang_y_i, ang_z_i, q);
        quat_q.push_back(q);
      end
      if (out_valid_i && out_ready_i) begin
        if (quat_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, quat_i);
        end else begin
          want = quat_q.pop_front();
          if (quat_i.w !== want.w) begin
            errors++;
            $display("%0t: w expected %0d got %0d", $time, want.w, quat_i.w);
          end
          if (quat_i.x !== want.x) begin
            errors++;
            $display("%0t: x expected %0d got %0d", $time, want.x, quat_i.x);
          end
          if (quat_i.y !== want.y) begin
            errors++;
            $display("%0t: y expected %0d got %0d", $time, want.y, quat_i.y);
          end
          if (quat_i.z !== want.z) begin
            errors++;
            $display("%0t: z expected %0d got %0d", $time, want.z, quat_i.z);
          end
        end
      end
    end
  end

  assign errors_o  = errors;
  assign pending_o = quat_q.size();
endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, stimulus and verdict for euler_to_quaternion_core
module tb_top;
  import e2q_pkg::*;

  typedef struct packed {
    angle_t x;
    angle_t y;
    angle_t z;
  } angles_t;

  localparam int PhaseItems = 650;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   tx_idle_pct = 13;
  int   rx_idle_pct = 69;
  bit   rx_hold_req = 1'b0;
  int   errors, pending;

  e2q_if #(.T(angles_t))    in_if ();
  e2q_if #(.T(quat_item_t)) out_if ();

  euler_to_quaternion_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  e2q_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .ang_x_i     (in_if.data.x),
    .ang_y_i     (in_if.data.y),
    .ang_z_i     (in_if.data.z),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .quat_i      (out_if.data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item at a falling edge and hold it until taken
  task automatic send_angles(input angle_t ax, input angle_t ay, input angle_t az);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = '{x: ax, y: ay, z: az};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic angle_t rand_angle();
    // mostly within +-360 degrees, sometimes any 17-bit code
    if ($urandom_range(9) == 0) return angle_t'($urandom);
    if ($urandom_range(9) == 0) return angle_t'($urandom_range(2) * 23040 - 23040);
    return angle_t'(int'($urandom_range(92160)) - 46080);
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  initial begin
    angle_t edge_vals [10] = '{17'sd0, 17'sd46080, -17'sd46080, 17'sd23040, -17'sd23040,
                              17'sd11520, 17'sd1, -17'sd1, 17'sd65535, -17'sd65536};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, quarter/half turns, saturation at zero rotation
    for (int i = 0; i < 10; i++) send_angles(edge_vals[i], 17'sd0, 17'sd0);
    for (int i = 0; i < 10; i++) send_angles(17'sd0, edge_vals[i], edge_vals[9 - i]);
    send_angles(17'sd46080, 17'sd46080, 17'sd46080);
    send_angles(-17'sd46080, 17'sd23040, 17'sd11520);
    send_angles(17'sd65535, -17'sd65536, 17'sd65535);
    send_random(PhaseItems - 23);

    tx_idle_pct = 69;
    rx_idle_pct = 13;
    send_random(PhaseItems);

    // No idling; a long receiver hold-off first so the pipeline backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    send_random(PhaseItems);
    in_if.valid = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_prep.sv
rtl/e2q_cell.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion_core.sv
rtl/e2q_checker.sv
tb/e2q_checker.sv
tb/tb_top.sv
